// File: hw/rtl/aubm_pkg.sv
// Package for the aging update buffer map: table capacity, operation codes,
// register indexes, sequencer states and the result beat struct. No dependencies.
`timescale 1ns / 1ps
package aubm_pkg;
	localparam int CAPACITY = 64;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_PURGE  = 3'd1;
	localparam logic [2:0] OP_LIST   = 3'd2;
	localparam logic [2:0] OP_TEST   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic REG_RETENTION = 1'b0;
	localparam logic REG_UPR       = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THRESH,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT,
		ST_FINAL
	} state_t;

	// result beat fields
	typedef struct packed {
		logic       last;
		logic       overflow;
		logic [6:0] entry_count;
		logic       found;
		logic [6:0] deleted_count;
		logic       has_update;
		logic [19:0] result_id;
	} result_t;
endpackage

// File: hw/rtl/aging_update_buffer_map.sv
// Aging update buffer map.
// Stream in: s_tvalid/s_tready/s_tdata carries one operation per beat.
// Stream out: m_tvalid/m_tready/m_tdata/m_tlast carries result beats; an
// operation yields one beat, except a listing, which yields one beat per
// matching entry (or one empty beat), m_tlast on the final one.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data writes retention_rounds
// (index 0) and updates_per_round (index 1); write only while idle.
// Entries (id and round) live in one synchronous memory of CAPACITY words.
// One operation runs at a time: an expiry threshold step, then (except for
// read entry) a scan over the fill count, one entry per cycle through the
// memory read port while the output is not stalled.
// Purge compacts in place during the scan (write trails read).
// Reset clears the fill count and sets config to retention 4, 16 updates per round; memory holds no reset.
// When the receiver stalls, the scan holds until the beat is taken.
`timescale 1ns / 1ps
module aging_update_buffer_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[2:0], round[18:3], update_id[38:19], span_rounds[54:39],
	// entry_index[60:55]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_id[19:0], has_update[20], deleted_count[27:21], found[28],
	// entry_count[35:29], overflow[36]
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import aubm_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t      state_q, state_d;
	logic [7:0]  ret_q;
	logic [10:0] upr_q;
	logic [CW-1:0] fill_q, rd_q, wr_q;
	logic [2:0]  op_q;
	logic [15:0] round_q, span_q;
	logic [19:0] id_q;
	logic [5:0]  idx_q;
	logic signed [28:0] thr_q;
	logic        hit_q, pend_q;
	logic [19:0] emit_id_q;
	logic        emit_has_q;

	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [35:0] mem_wd, mem_rd;

	aubm_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
		.raddr(mem_ra), .rdata(mem_rd)
	);

	logic [19:0] e_id;
	logic [15:0] e_rnd;
	logic        e_exp, e_inlist;
	logic signed [17:0] lo;
	assign e_id  = mem_rd[19:0];
	assign e_rnd = mem_rd[35:20];
	assign e_exp = $signed({9'd0, e_id}) < thr_q;
	assign lo    = $signed({2'b0, round_q}) - $signed({2'b0, span_q});
	assign e_inlist = ($signed({2'b0, e_rnd}) >= lo) && (e_rnd < round_q);

	logic id_exp;
	assign id_exp = $signed({9'd0, id_q}) < thr_q;

	logic append_ok;
	assign append_ok = (op_q == OP_INSERT) && !id_exp && !hit_q;

	// pend_q: a read was issued last cycle, data valid in mem_rd
	logic scan_done;
	assign scan_done = (rd_q == fill_q) && !pend_q;
	logic out_busy;
	assign out_busy = m_tvalid && !m_tready;

	assign s_tready  = (state_q == ST_IDLE) && !m_tvalid;
	assign cfg_ready = 1'b1;

	// re-read the pending entry while a beat is held
	always_comb begin
		mem_ra = rd_q[AW-1:0];
		if (op_q == OP_READ) mem_ra = AW'(idx_q);
		else if (state_q == ST_SCAN && pend_q && out_busy) mem_ra = AW'(rd_q - CW'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid && s_tready) state_d = ST_THRESH;
			ST_THRESH: begin
				if (op_q == OP_READ) state_d = ST_WAIT;
				else if (op_q > OP_READ) state_d = ST_FINAL;
				else state_d = ST_SCAN;
			end
			ST_SCAN:   if (scan_done && !out_busy) state_d = ST_FINAL;
			ST_WAIT:   state_d = ST_EMIT;
			ST_EMIT:   state_d = ST_FINAL;
			ST_FINAL:  if (!out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_q[AW-1:0];
		mem_wd = {round_q, id_q};
		if (state_q == ST_SCAN && pend_q && !out_busy) begin
			if (op_q == OP_PURGE && !e_exp) begin
				mem_we = 1'b1;
				mem_wd = mem_rd;
			end else if (op_q == OP_INSERT && e_id == id_q) begin
				mem_we = 1'b1;
				mem_wa = AW'(rd_q - CW'(1));
				mem_wd = {round_q, id_q};
			end
		end
		if (state_q == ST_FINAL && !out_busy && append_ok && fill_q < CW'(CAPACITY)) begin
			mem_we = 1'b1;
			mem_wa = fill_q[AW-1:0];
			mem_wd = {round_q, id_q};
		end
	end

	// result beat: a listing holds its latest match and sends the previous one
	// when the next match arrives, so the final match can carry m_tlast
	logic        load_beat, beat_last, fin_ovf;
	logic [6:0]  fin_cnt, fin_del;
	logic [39:0] beat_data;

	always_comb begin
		load_beat = 1'b0;
		beat_last = 1'b1;
		fin_cnt = fill_q[6:0];
		fin_del = 7'd0;
		fin_ovf = 1'b0;
		if (append_ok) begin
			if (fill_q < CW'(CAPACITY)) fin_cnt = 7'(fill_q + CW'(1));
			else fin_ovf = 1'b1;
		end
		if (op_q == OP_PURGE) begin
			fin_cnt = wr_q[6:0];
			fin_del = 7'(fill_q - wr_q);
		end
		beat_data = {3'd0, fin_ovf, fin_cnt, (op_q == OP_TEST) && hit_q, fin_del,
			1'b0, 20'd0};
		if ((op_q == OP_READ && emit_has_q) || (op_q == OP_LIST && hit_q))
			beat_data = {3'd0, 1'b0, fin_cnt, 1'b0, 7'd0, 1'b1, emit_id_q};
		if (state_q == ST_FINAL) load_beat = !out_busy;
		if (state_q == ST_SCAN && !out_busy && pend_q && op_q == OP_LIST && e_inlist &&
		    hit_q) begin
			load_beat = 1'b1;
			beat_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= 8'd4;
			upr_q <= 11'd16;
			fill_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			hit_q <= 1'b0;
			pend_q <= 1'b0;
			emit_id_q <= '0;
			emit_has_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == REG_RETENTION) ret_q <= cfg_data[7:0];
				else upr_q <= cfg_data;
			end
			if (load_beat) begin
				m_tvalid <= 1'b1;
				m_tdata <= beat_data;
				m_tlast <= beat_last;
			end else if (m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_q <= '0; wr_q <= '0;
					hit_q <= 1'b0; pend_q <= 1'b0;
				end
				ST_SCAN: begin
					if (!out_busy) begin
						if (pend_q && (op_q == OP_INSERT || op_q == OP_TEST) &&
						    e_id == id_q) begin
							// match found: stop the scan
							hit_q <= 1'b1;
							rd_q <= fill_q;
							pend_q <= 1'b0;
						end else begin
							pend_q <= (rd_q != fill_q) && !(op_q == OP_INSERT && id_exp);
							if (rd_q != fill_q) rd_q <= rd_q + CW'(1);
							if (pend_q && op_q == OP_PURGE && !e_exp) wr_q <= wr_q + CW'(1);
							if (pend_q && op_q == OP_LIST && e_inlist) begin
								hit_q <= 1'b1;
								emit_id_q <= e_id;
							end
						end
					end
				end
				ST_EMIT: begin
					emit_has_q <= (CW'(idx_q) < fill_q) && (CW'(idx_q) < CW'(CAPACITY));
					emit_id_q <= e_id;
				end
				ST_FINAL: begin
					if (!out_busy) begin
						if (append_ok && fill_q < CW'(CAPACITY)) fill_q <= fill_q + CW'(1);
						if (op_q == OP_PURGE) fill_q <= wr_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= s_tdata[2:0];
			round_q <= s_tdata[18:3];
			id_q <= s_tdata[38:19];
			span_q <= s_tdata[54:39];
			idx_q <= s_tdata[60:55];
		end
		if (state_q == ST_THRESH)
			thr_q <= 29'($signed({1'b0, round_q}) - $signed({9'b0, ret_q})) *
				$signed({18'd0, upr_q});
	end

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast));
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid);
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY));
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_we);
endmodule

// File: hw/rtl/aubm_mem.sv
// Synchronous entry memory, one write and one read port, registered read.
// Does not use aubm_pkg; stand-alone.
`timescale 1ns / 1ps
module aubm_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [35:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [35:0]   rdata
);
	logic [35:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
